// ----- hdl/sc3_pkg.sv -----
// Shared types and constants for the 3x3 sharpen filter.
`timescale 1ns / 1ps

package sc3_pkg;

	localparam int PIXEL_BITS    = 24;
	localparam int FILTERED_BITS = 28;
	localparam int MAX_COLS_DEF  = 1024;
	localparam int COLS_BITS     = 11;
	localparam int ROWS_BITS     = 16;
	localparam int OUTQ_DEPTH    = 4;

	localparam logic [COLS_BITS-1:0] COLS_RESET = 11'd1024;
	localparam logic [ROWS_BITS-1:0] ROWS_RESET = 16'd1024;

	typedef enum logic {
		REG_IMAGE_COLS = 1'b0,
		REG_IMAGE_ROWS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel;
		logic                         drain;
	} pix_beat_t;

	typedef struct packed {
		logic signed [FILTERED_BITS-1:0] filtered;
		logic                            run_last;
		logic                            frame_end;
	} res_beat_t;

endpackage

// ----- hdl/sharpen_conv3x3_zero_pad.sv -----
// Streaming 3x3 sharpen filter with zero padding and a two-row line memory.
`timescale 1ns / 1ps
//
// Pixels enter on the pix channel (valid/stall) in row-major order, one beat per
// pixel. Results leave on the res channel (valid/stall), up to two beats per
// pixel: output (r-1, c-1) for input (r, c), and at the last column of a row
// also output (r-1, last). run_last marks the final beat caused by one pixel,
// frame_end the bottom-right pixel. After a frame, send one row of drain beats
// to flush the last image row; row 0 produces no results.
// A result beat is registered in stage 1 and then held in the result queue.
// Throughput: one pixel per cycle while pix_stall is low. Each pixel does one
// read and one write of the line memory (above and center rows packed in one
// word) in consecutive cycles; a read of the word being written is forwarded.
// Results go through a 4-beat queue; the pix side stalls when the queue,
// counting this cycle's writes and read, could not take two more beats, which
// happens only once res stalls have backed the queue up.
// A stalled res side fills the queue and then stalls the pix side; no beat is
// lost. Reset returns to row 0, column 0 and the default register values; the
// line memory is not cleared (rows above the first are taken as zero).
// Registers (APB, byte address 4*i): 0 image_cols, 1 image_rows. Write them
// only while idle.

module sharpen_conv3x3_zero_pad import sc3_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  pix_beat_t   pix_data,
	output logic        res_valid,
	input  logic        res_stall,
	output res_beat_t   res_data
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int QW = $clog2(OUTQ_DEPTH);
	localparam int PB = PIXEL_BITS;
	localparam int FB = FILTERED_BITS;

	// configuration
	logic [COLS_BITS-1:0] image_cols_q;
	logic [ROWS_BITS-1:0] image_rows_q;
	logic                 cfg_wr;
	reg_idx_t             cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			REG_IMAGE_COLS: prdata = {{(32-COLS_BITS){1'b0}}, image_cols_q};
			REG_IMAGE_ROWS: prdata = {{(32-ROWS_BITS){1'b0}}, image_rows_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q <= COLS_RESET;
			image_rows_q <= ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_IMAGE_COLS: image_cols_q <= pwdata[COLS_BITS-1:0];
				REG_IMAGE_ROWS: image_rows_q <= pwdata[ROWS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage 0: position, read issue
	logic [AW-1:0]        col_q;
	logic [ROWS_BITS-1:0] row_q;
	logic [CW-1:0]        ncols;
	logic [CW-1:0]        col_inc;
	logic                 last_col;
	logic                 pix_acc;
	logic signed [PB-1:0] bot;

	assign pix_acc = pix_valid && !pix_stall;

	always_comb begin
		if (image_cols_q == '0)
			ncols = CW'(1);
		else if (32'(image_cols_q) > 32'(MAX_COLS))
			ncols = CW'(MAX_COLS);
		else
			ncols = CW'(image_cols_q);
	end

	assign col_inc  = CW'(col_q) + CW'(1);
	assign last_col = (col_inc >= ncols);
	assign bot      = (row_q >= image_rows_q || pix_data.drain) ? '0 : pix_data.pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (row_q >= image_rows_q) ? '0 : row_q + ROWS_BITS'(1);
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end
	end

	// stage 1 registers
	logic                   v_s1;
	logic                   fwd_hit_s1;
	logic [AW-1:0]          c_s1;
	logic signed [PB-1:0]   bot_s1;
	logic                   emit_s1;
	logic                   last_s1;
	logic                   frame_end_s1;
	logic                   has_top_s1;
	logic                   has_mid_s1;
	logic                   first_col_s1;
	logic [2*PB-1:0]        rd_s1;
	logic [2*PB-1:0]        fwd_data_s1;
	logic [2*PB-1:0]        line_mem_q [MAX_COLS];

	logic [2*PB-1:0]        mem_word;
	logic [2*PB-1:0]        wr_data;

	assign mem_word = fwd_hit_s1 ? fwd_data_s1 : rd_s1;
	assign wr_data  = {mem_word[PB-1:0], bot_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			v_s1       <= pix_acc;
			fwd_hit_s1 <= pix_acc && v_s1 && (c_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			c_s1         <= col_q;
			bot_s1       <= bot;
			emit_s1      <= (row_q != '0) && (row_q <= image_rows_q);
			last_s1      <= last_col;
			frame_end_s1 <= (row_q == image_rows_q);
			has_top_s1   <= (row_q >= ROWS_BITS'(2));
			has_mid_s1   <= (row_q != '0);
			first_col_s1 <= (col_q == '0);
		end
		fwd_data_s1 <= wr_data;
	end

	// line memory: {row above, center row} per column
	always_ff @(posedge clk) begin
		if (pix_acc)
			rd_s1 <= line_mem_q[col_q];
		if (v_s1)
			line_mem_q[c_s1] <= wr_data;
	end

	// stage 1: window and kernel sums
	logic signed [PB-1:0] w0_q, w1_q, w2_q, w4_q;
	logic signed [PB-1:0] top, mid, left;
	logic signed [FB-1:0] res0_val, res1_val;
	logic                 e0, e1;
	logic [1:0]           n_s1;

	function automatic logic signed [FB-1:0] ext(input logic signed [PB-1:0] x);
		return FB'(x);
	endfunction

	assign top  = has_top_s1 ? $signed(mem_word[2*PB-1:PB]) : '0;
	assign mid  = has_mid_s1 ? $signed(mem_word[PB-1:0]) : '0;
	assign left = first_col_s1 ? '0 : w1_q;

	assign res0_val = (ext(w1_q) <<< 2) + ext(w1_q) - ext(w0_q) - ext(w2_q)
		- ext(w4_q) - ext(mid);
	assign res1_val = (ext(mid) <<< 2) + ext(mid) - ext(top) - ext(bot_s1) - ext(left);

	assign e0   = v_s1 && emit_s1 && !first_col_s1;
	assign e1   = v_s1 && emit_s1 && last_s1;
	assign n_s1 = {1'b0, e0} + {1'b0, e1};

	always_ff @(posedge clk) begin
		if (v_s1) begin
			w0_q <= top;
			w1_q <= mid;
			w2_q <= bot_s1;
			w4_q <= first_col_s1 ? '0 : w1_q;
		end
	end

	// result queue
	res_beat_t   outq_q [OUTQ_DEPTH];
	logic [QW-1:0] wp_q, rp_q, wp_inc;
	logic [QW:0]   cnt_q;
	logic [QW+1:0] need;
	logic          pop;
	res_beat_t     beat0, beat1;

	assign beat0  = '{filtered: res0_val, run_last: !e1, frame_end: 1'b0};
	assign beat1  = '{filtered: res1_val, run_last: 1'b1, frame_end: frame_end_s1};
	assign wp_inc = wp_q + QW'(1);

	always_ff @(posedge clk) begin
		if (e0)
			outq_q[wp_q] <= beat0;
		if (e1)
			outq_q[e0 ? wp_inc : wp_q] <= beat1;
	end

	assign res_valid = (cnt_q != '0);
	assign res_data  = outq_q[rp_q];
	assign pop       = res_valid && !res_stall;
	assign need      = (QW+2)'(cnt_q) + (QW+2)'(n_s1) + (QW+2)'(2) - (QW+2)'(pop);
	assign pix_stall = (need > (QW+2)'(OUTQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QW'(n_s1);
			rp_q  <= rp_q + QW'(pop);
			cnt_q <= cnt_q + (QW+1)'(n_s1) - (QW+1)'(pop);
		end
	end

endmodule

// ----- hdl/sc3_chk.sv -----
// Port-level checks for the sharpen filter, bound to the top level.
`timescale 1ns / 1ps

module sc3_chk import sc3_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      pix_valid,
	input logic      pix_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_beat_t res_data
);

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("res beat changed while stalled");

	// frame end is always the last beat of its pixel
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.frame_end |-> res_data.run_last)
		else $error("frame_end without run_last");

	// both beats of a pixel are queued together
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_data.run_last |=> res_valid)
		else $error("second beat of a pixel missing");

	// first result after an empty queue follows an accepted pixel through stage 1 and the queue
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pix_valid && !pix_stall, 2))
		else $error("result without an accepted pixel");

endmodule

bind sharpen_conv3x3_zero_pad sc3_chk u_sc3_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_stall (pix_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

// ----- test/sharpen_result_check.sv -----
// Checker for the 3x3 sharpen filter: predicts result beats from observed pixel beats and compares.
`timescale 1ns / 1ps

module sharpen_result_check import sc3_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        pix_valid,
	input  logic        pix_stall,
	input  pix_beat_t   pix_data,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_beat_t   res_data,
	output int          errors,
	output int          pending
);

	logic [COLS_BITS-1:0] cols_cfg;
	logic [ROWS_BITS-1:0] rows_cfg;
	int                   above_row [MAX_COLS];
	int                   center_row [MAX_COLS];
	int                   win [6];
	int                   col_pos;
	int                   row_pos;
	res_beat_t            sharpened_q [$];

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("[%0t] %s", $realtime, msg);
		errors++;
	endtask

	task automatic sharpen_pixel(input pix_beat_t b);
		int        ncols;
		int        r;
		int        c;
		int        top;
		int        mid;
		int        bot;
		int        sum;
		logic      last_col;
		logic      emit;
		res_beat_t beat;
		ncols = int'(cols_cfg);
		if (ncols == 0)
			ncols = 1;
		if (ncols > MAX_COLS)
			ncols = MAX_COLS;
		r = row_pos;
		c = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
		last_col = (c + 1 >= ncols);
		top = (r >= 2) ? above_row[c] : 0;
		mid = (r >= 1) ? center_row[c] : 0;
		bot = (r >= int'(rows_cfg) || b.drain) ? 0 : int'($signed(b.pixel));
		if (c == 0)
			foreach (win[i])
				win[i] = 0;
		emit = (r >= 1 && r <= int'(rows_cfg));
		if (emit && c >= 1) begin
			sum = 5 * win[1] - win[0] - win[2] - win[4] - mid;
			beat.filtered  = sum[FILTERED_BITS-1:0];
			beat.run_last  = !last_col;
			beat.frame_end = 1'b0;
			sharpened_q.push_back(beat);
		end
		if (emit && last_col) begin
			sum = 5 * mid - top - bot - win[1];
			beat.filtered  = sum[FILTERED_BITS-1:0];
			beat.run_last  = 1'b1;
			beat.frame_end = (r == int'(rows_cfg));
			sharpened_q.push_back(beat);
		end
		win[3] = win[0];
		win[4] = win[1];
		win[5] = win[2];
		win[0] = top;
		win[1] = mid;
		win[2] = bot;
		above_row[c]  = center_row[c];
		center_row[c] = bot;
		if (last_col) begin
			col_pos = 0;
			row_pos = (r >= int'(rows_cfg)) ? 0 : ((r + 1) & 16'hFFFF);
		end else begin
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_beat_t want;
		if (!arst_n) begin
			cols_cfg = COLS_RESET;
			rows_cfg = ROWS_RESET;
			foreach (above_row[i]) begin
				above_row[i]  = 0;
				center_row[i] = 0;
			end
			foreach (win[i])
				win[i] = 0;
			col_pos = 0;
			row_pos = 0;
			sharpened_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_IMAGE_COLS: cols_cfg = pwdata[COLS_BITS-1:0];
					REG_IMAGE_ROWS: rows_cfg = pwdata[ROWS_BITS-1:0];
				endcase
			end
			if (res_valid && !res_stall) begin
				if (sharpened_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result beat, filtered %0d",
						$signed(res_data.filtered)));
				end else begin
					want = sharpened_q.pop_front();
					if (res_data.filtered !== want.filtered)
						report_mismatch($sformatf("filtered: got %0d want %0d",
							$signed(res_data.filtered), $signed(want.filtered)));
					if (res_data.run_last !== want.run_last)
						report_mismatch($sformatf("run_last: got %b want %b",
							res_data.run_last, want.run_last));
					if (res_data.frame_end !== want.frame_end)
						report_mismatch($sformatf("frame_end: got %b want %b",
							res_data.frame_end, want.frame_end));
				end
			end
			if (pix_valid && !pix_stall)
				sharpen_pixel(pix_data);
			pending = sharpened_q.size();
		end
	end

endmodule

// ----- test/sharpen_conv3x3_zero_pad_tb.sv -----
// Testbench top for the 3x3 sharpen filter: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

module sharpen_conv3x3_zero_pad_tb;
	import sc3_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 800;
	localparam logic signed [PIXEL_BITS-1:0] PX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
	localparam logic signed [PIXEL_BITS-1:0] PX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};
	localparam logic signed [PIXEL_BITS-1:0] PX_NEG1 = '1;
	localparam logic signed [PIXEL_BITS-1:0] PX_ZERO = '0;
	localparam logic signed [PIXEL_BITS-1:0] PX_ONE = 24'sd1024;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pix_valid;
	logic        pix_stall;
	pix_beat_t   pix_data;
	logic        res_valid;
	logic        res_stall;
	res_beat_t   res_data;
	int          fail_count;
	int          pending_beats;
	int          quiet_cycles;
	int          src_mode;
	int          snk_mode;
	int          pixels_sent;

	sharpen_conv3x3_zero_pad u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	sharpen_result_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.errors    (fail_count),
		.pending   (pending_beats)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 2);
			default: return $urandom_range(0, 11);
		endcase
	endfunction

	function automatic logic signed [PIXEL_BITS-1:0] rand_pixel();
		case ($urandom_range(0, 11))
			0: return PX_MIN;
			1: return PX_MAX;
			2: return PX_ZERO;
			3: return PX_NEG1;
			default: return PIXEL_BITS'($urandom());
		endcase
	endfunction

	function automatic int row_len(input int cols_val);
		if (cols_val == 0)
			return 1;
		if (cols_val > MAX_COLS_DEF)
			return MAX_COLS_DEF;
		return cols_val;
	endfunction

	// all tasks below start and end at a falling edge
	task automatic send_pixel(input logic signed [PIXEL_BITS-1:0] px, input logic drn);
		int        gap;
		pix_beat_t beat;
		if (pixels_sent % 50 == 0)
			src_mode = $urandom_range(0, 2);
		gap = pick_gap(src_mode);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		beat.pixel = px;
		beat.drain = drn;
		pix_data  <= beat;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!(pix_valid && !pix_stall));
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic settle();
		pix_valid <= 1'b0;
		while (pending_beats != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_geometry(input int cols_val, input int rows_val);
		reg_write(REG_IMAGE_COLS, cols_val);
		reg_write(REG_IMAGE_ROWS, rows_val);
	endtask

	// frame of random pixels followed by the drain row
	task automatic send_frame(input int len, input int nrows);
		for (int i = 0; i < (nrows + 1) * len; i++) begin
			if (i < nrows * len)
				send_pixel(rand_pixel(), $urandom_range(0, 31) == 0);
			else
				send_pixel(rand_pixel(), $urandom_range(0, 7) != 0);
		end
	endtask

	initial begin : res_sink
		int gap;
		int beats;
		res_stall = 1'b0;
		snk_mode  = 0;
		beats     = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (beats % 40 == 0)
				snk_mode = $urandom_range(0, 2);
			gap = pick_gap(snk_mode);
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!(res_valid && !res_stall));
			beats++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		int cols_val;
		int rows_val;
		int start_count;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		pix_valid    = 1'b0;
		pix_data     = '0;
		src_mode     = 0;
		pixels_sent  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 4x3 frame hitting the largest and smallest sums, drain inside the frame
		set_geometry(4, 3);
		send_pixel(PX_ONE, 1'b0);
		send_pixel(PX_MIN, 1'b0);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_NEG1, 1'b0);
		send_pixel(PX_MIN, 1'b0);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_MIN, 1'b0);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_MIN, 1'b0);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_MAX, 1'b1);
		send_pixel(PX_MAX, 1'b1);
		send_pixel(PX_ZERO, 1'b1);
		send_pixel(PX_MIN, 1'b0);
		send_pixel(PX_NEG1, 1'b1);
		settle();

		// column register zero: single-column image
		set_geometry(0, 2);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_MIN, 1'b0);
		send_pixel(PX_MAX, 1'b1);
		settle();

		// row register zero: no results at all
		set_geometry(2, 0);
		send_pixel(PX_MAX, 1'b0);
		send_pixel(PX_MIN, 1'b0);
		settle();

		// mid-frame changes: row end moved early, then frame cut short
		set_geometry(3, 16'hFFFF);
		repeat (8) send_pixel(rand_pixel(), 1'b0);
		settle();
		reg_write(REG_IMAGE_COLS, 2);
		repeat (3) send_pixel(rand_pixel(), 1'b0);
		settle();
		reg_write(REG_IMAGE_ROWS, 2);
		repeat (2) send_pixel(rand_pixel(), 1'b0);
		settle();

		// widest row, column register above the limit, no image rows
		set_geometry(11'h7FF, 0);
		send_frame(MAX_COLS_DEF, 0);
		settle();

		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: cols_val = $urandom_range(1, 2);
				1: cols_val = $urandom_range(17, 64);
				default: cols_val = $urandom_range(1, 16);
			endcase
			rows_val = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			set_geometry(cols_val, rows_val);
			send_frame(row_len(cols_val), rows_val);
			settle();
		end

		pix_valid <= 1'b0;
		while (pending_beats != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/sc3_pkg.sv
hdl/sharpen_conv3x3_zero_pad.sv
hdl/sc3_chk.sv
test/sharpen_result_check.sv
test/sharpen_conv3x3_zero_pad_tb.sv
